// File: hdl/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg
// Shared types and constants of the line rasterizer: payload structs, the
// segment descriptor passed from the front end to the walker, register codes.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam int COORD_BITS = 12;
  localparam int CFG_BITS   = 13;
  localparam int ADDR_BITS  = 26;
  localparam int PROD_BITS  = COORD_BITS + CFG_BITS;

  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RST  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] IMAGE_HEIGHT_RST = CFG_BITS'(480);

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } seg_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         inside_res;
    logic [ADDR_BITS-1:0]         byte_address;
    logic                         too_long;
    logic                         last;
  } pix_out_t;

  // classified segment, queued between front end and walker
  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COORD_BITS-1:0]        span_x;
    logic [COORD_BITS-1:0]        span_y;
    logic                         step_x_neg;
    logic                         step_y_neg;
    logic                         too_long;
  } seg_desc_t;

  // one visited pixel leaving the walker
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         too_long;
    logic                         last;
  } walk_pix_t;

endpackage

// File: hdl/blr_front.sv
// ----------------------------------------------------------------------------
// blr_front
// Accepts segments and classifies them: spans, step directions, too-long.
// ----------------------------------------------------------------------------
module blr_front import blr_pkg::*; #(
  parameter int MAX_SPAN = 63
) (
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  seg_in_t   in_data_i,
  input  logic      fifo_full_i,
  output logic      push_o,
  output seg_desc_t desc_o
);

  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0]        abs_x, abs_y;

  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  always_comb begin
    dx = {in_data_i.end_x[COORD_BITS-1], in_data_i.end_x}
       - {in_data_i.start_x[COORD_BITS-1], in_data_i.start_x};
    dy = {in_data_i.end_y[COORD_BITS-1], in_data_i.end_y}
       - {in_data_i.start_y[COORD_BITS-1], in_data_i.start_y};
    abs_x = dx[COORD_BITS] ? -dx : dx;
    abs_y = dy[COORD_BITS] ? -dy : dy;

    desc_o.start_x    = in_data_i.start_x;
    desc_o.start_y    = in_data_i.start_y;
    desc_o.end_x      = in_data_i.end_x;
    desc_o.end_y      = in_data_i.end_y;
    desc_o.span_x     = abs_x[COORD_BITS-1:0];
    desc_o.span_y     = abs_y[COORD_BITS-1:0];
    desc_o.step_x_neg = !(in_data_i.start_x < in_data_i.end_x);
    desc_o.step_y_neg = !(in_data_i.start_y < in_data_i.end_y);
    desc_o.too_long   = (abs_x > (COORD_BITS+1)'(MAX_SPAN))
                     || (abs_y > (COORD_BITS+1)'(MAX_SPAN));
  end

endmodule

// File: hdl/blr_fifo.sv
// ----------------------------------------------------------------------------
// blr_fifo
// Short segment queue decoupling the front end from the walker.
// ----------------------------------------------------------------------------
module blr_fifo import blr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  seg_desc_t push_data_i,
  input  logic      pop_i,
  output seg_desc_t pop_data_o,
  output logic      full_o,
  output logic      empty_o
);

  seg_desc_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_BITS:0]   count_q;

  assign full_o     = (count_q == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: hdl/blr_walker.sv
// ----------------------------------------------------------------------------
// blr_walker
// Bresenham stepper: loads one segment, emits one pixel per advancing cycle.
// ----------------------------------------------------------------------------
module blr_walker import blr_pkg::*; #(
  parameter int MAX_SPAN = 63
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      desc_valid_i,
  input  seg_desc_t desc_i,
  output logic      pop_o,
  input  logic      adv_i,
  output logic      pix_valid_o,
  output walk_pix_t pix_o
);

  localparam int SPAN_BITS = $clog2(MAX_SPAN + 1);
  localparam int ERR_BITS  = SPAN_BITS + 3;

  logic                         busy_q;
  logic                         too_long_q;
  logic signed [COORD_BITS-1:0] cx_q, cy_q, tx_q, ty_q;
  logic signed [COORD_BITS-1:0] cx_d, cy_d;
  logic signed [ERR_BITS-1:0]   err_q, err_d;
  logic [SPAN_BITS-1:0]         sx_q, sy_q;
  logic                         nx_q, ny_q;

  logic                         at_end, fire;
  logic signed [ERR_BITS:0]     e2, span_x_e, span_y_e;

  assign pop_o       = !busy_q && desc_valid_i;
  assign pix_valid_o = busy_q;
  assign at_end      = (cx_q == tx_q) && (cy_q == ty_q);
  assign fire        = busy_q && adv_i;

  always_comb begin
    pix_o.x        = too_long_q ? '0 : cx_q;
    pix_o.y        = too_long_q ? '0 : cy_q;
    pix_o.too_long = too_long_q;
    pix_o.last     = too_long_q || at_end;

    span_x_e = (ERR_BITS+1)'(sx_q);
    span_y_e = (ERR_BITS+1)'(sy_q);
    e2       = {err_q, 1'b0};
    err_d    = err_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    if (e2 > -span_y_e) begin
      err_d = err_d - ERR_BITS'(sy_q);
      cx_d  = nx_q ? cx_q - 1'b1 : cx_q + 1'b1;
    end
    if (e2 < span_x_e) begin
      err_d = err_d + ERR_BITS'(sx_q);
      cy_d  = ny_q ? cy_q - 1'b1 : cy_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
    end else if (fire && pix_o.last) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      too_long_q <= desc_i.too_long;
      cx_q       <= desc_i.start_x;
      cy_q       <= desc_i.start_y;
      tx_q       <= desc_i.end_x;
      ty_q       <= desc_i.end_y;
      sx_q       <= desc_i.span_x[SPAN_BITS-1:0];
      sy_q       <= desc_i.span_y[SPAN_BITS-1:0];
      nx_q       <= desc_i.step_x_neg;
      ny_q       <= desc_i.step_y_neg;
      err_q      <= ERR_BITS'(desc_i.span_x[SPAN_BITS-1:0])
                  - ERR_BITS'(desc_i.span_y[SPAN_BITS-1:0]);
    end else if (fire && !pix_o.last) begin
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      err_q <= err_d;
    end
  end

endmodule

// File: hdl/blr_pixel_pipe.sv
// ----------------------------------------------------------------------------
// blr_pixel_pipe
// Clip test and address generation: multiply stage, then the output register.
// ----------------------------------------------------------------------------
module blr_pixel_pipe import blr_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CFG_BITS-1:0] image_width_i,
  input  logic [CFG_BITS-1:0] image_height_i,
  input  logic                pix_valid_i,
  input  walk_pix_t           pix_i,
  output logic                adv_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pix_out_t            out_data_o
);

  logic                   v1_q, out_valid_q;
  walk_pix_t              p1_q;
  logic                   in1_q;
  logic [PROD_BITS-1:0]   prod1_q;
  logic                   in_img;
  logic [ADDR_BITS-1:0]   sum;
  pix_out_t               out_q;

  // whole pipe moves as one; stalls only when the output beat is held
  assign adv_o       = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_img = !pix_i.too_long && !pix_i.x[COORD_BITS-1] && !pix_i.y[COORD_BITS-1]
               && ({1'b0, pix_i.x} < image_width_i)
               && ({1'b0, pix_i.y} < image_height_i);

  assign sum = ADDR_BITS'(prod1_q) + ADDR_BITS'(unsigned'(p1_q.x));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      v1_q        <= pix_valid_i;
      out_valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      p1_q    <= pix_i;
      in1_q   <= in_img;
      prod1_q <= PROD_BITS'(unsigned'(pix_i.y) * image_width_i);

      out_q.pixel_x      <= p1_q.x;
      out_q.pixel_y      <= p1_q.y;
      out_q.inside_res   <= in1_q;
      out_q.byte_address <= in1_q ? ADDR_BITS'(sum * CHANNELS) : '0;
      out_q.too_long     <= p1_q.too_long;
      out_q.last         <= p1_q.last;
    end
  end

endmodule

// File: hdl/bresenham_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit
// Segment rasterizer: one beat out per visited pixel, with clip flag and
// interleaved-image byte address.
// ----------------------------------------------------------------------------
// A segment whose spans are dx and dy produces max(dx, dy) + 1 pixel beats,
// one per cycle from the walker while the pipe does not stall, once loaded from
// the two-entry queue; a rejected (too long) segment gives a single beat. The
// first beat passes the queue, walker, multiply stage and output register.
// Segments are accepted into the queue while the walker is still drawing the
// previous one. The user must write configuration registers through cfg_we_i /
// cfg_idx_i / cfg_data_i only while the block is idle; the block does not enforce it.
module bresenham_line_rasterizer_unit import blr_pkg::*; #(
  parameter int MAX_SPAN = 63,
  parameter int CHANNELS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  cfg_reg_e            cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  seg_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pix_out_t            out_data_o
);

  logic [CFG_BITS-1:0] image_width_q, image_height_q;
  logic                fifo_full, fifo_empty, push, pop, adv, pix_valid;
  seg_desc_t           push_desc, pop_desc;
  walk_pix_t           pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMAGE_WIDTH_RST;
      image_height_q <= IMAGE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  blr_front #(.MAX_SPAN(MAX_SPAN)) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  blr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (pop),
    .pop_data_o  (pop_desc),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  blr_walker #(.MAX_SPAN(MAX_SPAN)) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (!fifo_empty),
    .desc_i       (pop_desc),
    .pop_o        (pop),
    .adv_i        (adv),
    .pix_valid_o  (pix_valid),
    .pix_o        (pix)
  );

  blr_pixel_pipe #(.CHANNELS(CHANNELS)) u_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .pix_valid_i    (pix_valid),
    .pix_i          (pix),
    .adv_o          (adv),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

  // rejected segment: single terminal beat with no pixel data
  a_too_long_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.too_long |->
      out_data_o.last && !out_data_o.inside_res
      && out_data_o.pixel_x == '0 && out_data_o.pixel_y == '0)
    else $error("too-long beat malformed");

  a_outside_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.inside_res |-> out_data_o.byte_address == '0)
    else $error("address set on clipped pixel");

  // queue full must block the input side
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_full |-> !in_ready_o && !push)
    else $error("segment queue overflow");

  a_pop_when_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_empty && !pix_valid)
    else $error("walker loaded while busy or queue empty");

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Bresenham line rasterizer. Segments go in on a
// valid/ready channel with bursty timing, pixel beats come out under a
// changing back-pressure pattern. A scoreboard walks every accepted segment
// itself and checks each pixel beat against it, over several image sizes.
// ----------------------------------------------------------------------------
module tb;
  import blr_pkg::*;

  localparam int MAX_SPAN    = 63;
  localparam int CHANNELS    = 3;
  localparam int WALK_LIMIT  = 64;
  localparam int SETTLE      = 8;
  localparam int STALL_LIMIT = 2000;

  // --------------------------------------------------------------------------
  // expected pixel stream, built from each accepted segment
  // --------------------------------------------------------------------------
  class pixel_scoreboard;
    pix_out_t            expected_q[$];
    logic [CFG_BITS-1:0] width_cfg;
    logic [CFG_BITS-1:0] height_cfg;
    int                  errors;

    function new();
      width_cfg  = IMAGE_WIDTH_RST;
      height_cfg = IMAGE_HEIGHT_RST;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_BITS-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:  width_cfg  = val;
        REG_IMAGE_HEIGHT: height_cfg = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function pix_out_t pixel_at(int x, int y);
      pix_out_t p;
      bit       in_img;
      p = '0;
      in_img = x >= 0 && y >= 0 && x < int'(width_cfg) && y < int'(height_cfg);
      p.pixel_x    = COORD_BITS'(x);
      p.pixel_y    = COORD_BITS'(y);
      p.inside_res = in_img;
      if (in_img) p.byte_address = ADDR_BITS'((y * int'(width_cfg) + x) * CHANNELS);
      return p;
    endfunction

    function void note_segment(seg_in_t seg);
      int       cx, cy, tx, ty, sx, sy, err, e2, n;
      bit       neg_x, neg_y;
      pix_out_t p;
      cx = seg.start_x;
      cy = seg.start_y;
      tx = seg.end_x;
      ty = seg.end_y;
      sx = (tx > cx) ? tx - cx : cx - tx;
      sy = (ty > cy) ? ty - cy : cy - ty;
      neg_x = !(cx < tx);
      neg_y = !(cy < ty);
      if (sx > MAX_SPAN || sy > MAX_SPAN) begin
        p = '0;
        p.too_long = 1'b1;
        p.last     = 1'b1;
        expected_q = {expected_q, p};
        return;
      end
      err = sx - sy;
      for (n = 0; n < WALK_LIMIT; n++) begin
        p = pixel_at(cx, cy);
        expected_q = {expected_q, p};
        if (cx == tx && cy == ty) break;
        e2 = err * 2;
        if (e2 > -sy) begin
          err -= sy;
          cx  += neg_x ? -1 : 1;
        end
        if (e2 < sx) begin
          err += sx;
          cy  += neg_y ? -1 : 1;
        end
      end
      expected_q[expected_q.size()-1].last = 1'b1;
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t exp_pix;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pixel beat: x=%0d y=%0d long=%0b last=%0b",
                   got.pixel_x, got.pixel_y, got.too_long, got.last);
        return;
      end
      exp_pix = expected_q.pop_front();
      if (got.pixel_x !== exp_pix.pixel_x || got.pixel_y !== exp_pix.pixel_y ||
          got.inside_res !== exp_pix.inside_res ||
          got.byte_address !== exp_pix.byte_address ||
          got.too_long !== exp_pix.too_long || got.last !== exp_pix.last) begin
        errors++;
        if (errors <= 10)
          $display("pixel mismatch: exp x=%0d y=%0d in=%0b addr=%0d long=%0b last=%0b",
                   exp_pix.pixel_x, exp_pix.pixel_y, exp_pix.inside_res,
                   exp_pix.byte_address, exp_pix.too_long, exp_pix.last,
                   " | got x=%0d y=%0d in=%0b addr=%0d long=%0b last=%0b",
                   got.pixel_x, got.pixel_y, got.inside_res,
                   got.byte_address, got.too_long, got.last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals
  // --------------------------------------------------------------------------
  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  cfg_reg_e            cfg_idx_i  = REG_IMAGE_WIDTH;
  logic [CFG_BITS-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  seg_in_t             in_data_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  pix_out_t            out_data_o;

  pixel_scoreboard book = new();

  bresenham_line_rasterizer_unit #(
    .MAX_SPAN (MAX_SPAN),
    .CHANNELS (CHANNELS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // receiver: back-pressure pattern switches at random between modes
  // (always ready, sparse random stalls, long stall runs)
  // --------------------------------------------------------------------------
  int ready_mode = 0;
  int mode_left  = 0;
  int stall_left = 0;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 15);
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) book.check_pixel(out_data_o);
  end

  // watchdog: too long without any beat moving on either side
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------
  task automatic push_segment(seg_in_t seg);
    in_valid_i <= 1'b1;
    in_data_i  <= seg;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_segment(seg);
  endtask

  task automatic draw(int x0, int y0, int x1, int y1);
    seg_in_t seg;
    seg.start_x = COORD_BITS'(x0);
    seg.start_y = COORD_BITS'(y0);
    seg.end_x   = COORD_BITS'(x1);
    seg.end_y   = COORD_BITS'(y1);
    push_segment(seg);
  endtask

  task automatic hold_off(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_image(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_IMAGE_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    book.set_reg(REG_IMAGE_WIDTH, w);
    cfg_idx_i  <= REG_IMAGE_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    book.set_reg(REG_IMAGE_HEIGHT, h);
    cfg_we_i   <= 1'b0;
  endtask

  // mostly near the image, sometimes anywhere in the coordinate range
  function automatic int pick_coord(int extent);
    int lim;
    if ($urandom_range(0, 2) == 0) return int'($urandom_range(0, 4095)) - 2048;
    lim = (extent > 2030) ? 2030 : extent;
    return int'($urandom_range(0, lim + 16)) - 8;
  endfunction

  function automatic int end_coord(int start, int delta);
    int e;
    e = start + delta;
    if (e > 2047 || e < -2048) e = start - delta;
    return e;
  endfunction

  function automatic seg_in_t random_segment();
    int      kind, lim, dx, dy, x0, y0, x1, y1;
    seg_in_t seg;
    kind = $urandom_range(0, 99);
    lim  = (kind < 50) ? 7 : (kind < 80) ? 20 : MAX_SPAN;
    dx   = int'($urandom_range(0, 2 * lim)) - lim;
    dy   = int'($urandom_range(0, 2 * lim)) - lim;
    x0   = pick_coord(int'(book.width_cfg));
    y0   = pick_coord(int'(book.height_cfg));
    if (kind >= 92 && kind < 96) begin
      // just past the span limit on one axis
      if ($urandom_range(0, 1)) dx = ($urandom_range(0, 1) ? 1 : -1) * (64 + $urandom_range(0, 3));
      else dy = ($urandom_range(0, 1) ? 1 : -1) * (64 + $urandom_range(0, 3));
    end
    x1 = end_coord(x0, dx);
    y1 = end_coord(y0, dy);
    if (kind >= 96) begin
      x1 = int'($urandom_range(0, 4095)) - 2048;
      y1 = int'($urandom_range(0, 4095)) - 2048;
    end
    seg.start_x = COORD_BITS'(x0);
    seg.start_y = COORD_BITS'(y0);
    seg.end_x   = COORD_BITS'(x1);
    seg.end_y   = COORD_BITS'(y1);
    return seg;
  endfunction

  task automatic run_random(int count);
    int burst_left, i;
    burst_left = 0;
    for (i = 0; i < count; i++) begin
      if (i == count / 2) wait_idle();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
      end
      burst_left--;
      push_segment(random_segment());
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset image size 640x480
    draw(5, 5, 5, 5);
    draw(0, 0, 10, 0);
    draw(10, 3, 0, 3);
    draw(2, 0, 2, 12);
    draw(2, 12, 2, 0);
    draw(0, 0, 7, 7);
    draw(7, 0, 0, 7);
    draw(20, 20, 27, 23);
    draw(20, 20, 23, 27);
    draw(20, 20, 13, 23);
    draw(20, 20, 17, 27);
    draw(20, 20, 13, 17);
    draw(20, 20, 17, 13);
    draw(20, 20, 27, 17);
    draw(20, 20, 23, 13);
    draw(0, 0, 63, 10);
    draw(100, 100, 90, 37);
    draw(0, 0, 64, 0);
    draw(0, 0, 0, -64);
    draw(-2048, -2048, 2047, 2047);
    draw(2047, 2047, 1984, 1990);
    draw(-2048, -2048, -1985, -2048);
    draw(-3, -2, 4, 3);
    draw(636, 476, 643, 483);
    draw(639, 479, 640, 479);

    set_image(13'd1, 13'd1);
    run_random(40);
    set_image(13'd4096, 13'd4096);
    run_random(50);
    set_image(13'd0, 13'd4096);
    run_random(40);
    set_image(13'd8191, 13'd0);
    run_random(40);
    set_image(13'd8191, 13'd8191);
    run_random(40);
    repeat (3) begin
      set_image(CFG_BITS'($urandom_range(0, 2) == 0 ? $urandom_range(0, 8191)
                                                    : $urandom_range(1, 96)),
                CFG_BITS'($urandom_range(0, 2) == 0 ? $urandom_range(0, 8191)
                                                    : $urandom_range(1, 96)));
      run_random(45);
    end

    wait_idle();
    repeat (2 * SETTLE) @(posedge clk_i);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
